// File: rtl/assert_macros.svh
// Assertion macros shared by the summed-area table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define SAT_ASSERT_ON(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Concurrent check on the block clock clk and reset rst_n.
`define SAT_ASSERT(lbl, prop, msg) \
  `SAT_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

// File: rtl/sat_pkg.sv
// Package: types, sizes and helpers for the summed-area table generator.
`default_nettype none
package sat_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_HEIGHT  = 1024;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ROW_TOT_W = 26;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = DIM_W;

  // only the low SAMPLE_BITS bits of a sample count
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
  } pix_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic             frame_end;
  } pix_out_t;

  // control shared by all channel lanes
  typedef struct packed {
    logic             load;       // pixel transfer in: add sample, read line store
    logic             clr_row;    // pixel is last of its row
    logic [COL_W-1:0] rd_col;
    logic             move;       // pixel leaves the sum stage: write line store
    logic [COL_W-1:0] wr_col;
    logic             use_above;  // not the first row
    logic             fwd;        // previous pixel wrote the entry just read
  } lane_ctl_t;

  // zero reads as one, oversize as the maximum
  function automatic logic [31:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    logic [31:0] vv;
    vv = 32'(v);
    if (vv == 32'd0) return 32'd1;
    if (vv > maxv)   return maxv;
    return vv;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sat_lane.sv
// One colour lane: running row total, line store and summed-area add.
`default_nettype none
module sat_lane
  import sat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lane_ctl_t           ctl,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [SUM_W-1:0]    sum
);

  logic [ROW_TOT_W-1:0] row_total_r;
  logic [ROW_TOT_W-1:0] row_total_nxt;
  logic [ROW_TOT_W-1:0] s1_row_r;
  logic [SUM_W-1:0]     rdata_r;
  logic [SUM_W-1:0]     last_sum_r;
  logic [SUM_W-1:0]     above;
  logic [SUM_W-1:0]     line_mem [MAX_WIDTH];

  assign row_total_nxt = row_total_r + ROW_TOT_W'(sample & SAMPLE_MASK);

  // running row total, cleared after the last pixel of a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_total_r <= '0;
    end else if (ctl.load) begin
      row_total_r <= ctl.clr_row ? '0 : row_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s1_row_r <= row_total_nxt;
    end
  end

  // line store: read on transfer in, write as the pixel leaves
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rdata_r <= line_mem[ctl.rd_col];
    end
    if (ctl.move) begin
      line_mem[ctl.wr_col] <= sum;
    end
  end

  // copy of the last written sum, for a one-pixel-wide frame
  always_ff @(posedge clk) begin
    if (ctl.move) begin
      last_sum_r <= sum;
    end
  end

  always_comb begin
    if (!ctl.use_above) above = '0;
    else if (ctl.fwd)   above = last_sum_r;
    else                above = rdata_r;
  end

  assign sum = SUM_W'(s1_row_r) + above;

endmodule
`default_nettype wire

// File: rtl/sat_merge.sv
// Output register: merges the three lane sums and the frame-end flag.
`default_nettype none
module sat_merge
  import sat_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             move,
  input  wire logic [SUM_W-1:0] red_sum,
  input  wire logic [SUM_W-1:0] green_sum,
  input  wire logic [SUM_W-1:0] blue_sum,
  input  wire logic             frame_end,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pix_out_t              out_data
);

  logic     out_valid_r;
  pix_out_t out_data_r;

  // room when empty or when the held result transfers this cycle
  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r.red_sum   <= red_sum;
      out_data_r.green_sum <= green_sum;
      out_data_r.blue_sum  <= blue_sum;
      out_data_r.frame_end <= frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/summed_area_table_generator_unit.sv
// Top level of the summed-area table generator: position tracking, lanes, output.
`default_nettype none
`include "assert_macros.svh"
// Takes RGB pixels in raster order and returns, one result per pixel, the
// summed-area value of each channel from the frame's top-left pixel to this
// pixel inclusive, with frame_end set on the last pixel. Throughput is one
// pixel per clock while the output is not stalled; a result is offered once its
// pixel has passed the line store read stage and then the output register. The
// input stalls only while both stages hold a pixel and the output is stalled.
// The rate is set by the single read and single write port of each lane's
// line store, one access of each per pixel. The line stores are not cleared:
// the first row of a frame ignores what it reads from them. image_width and
// image_height are read as 1 when zero and as the maximum when larger; writes
// take effect at once.
module summed_area_table_generator_unit
  import sat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pix_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pix_out_t                   out_data
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W:0]   width_eff;
  logic [ROW_W:0]   height_eff;
  logic             last_col;
  logic             last_row;
  logic             accept;
  logic             take;
  logic             s1_valid_r;
  logic             s1_move;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_above_r;
  logic             s1_fwd_r;
  logic             s1_end_r;
  lane_ctl_t        ctl;
  logic [SUM_W-1:0] red_sum;
  logic [SUM_W-1:0] green_sum;
  logic [SUM_W-1:0] blue_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign width_eff  = (COL_W+1)'(clamp_dim(width_r, MAX_WIDTH));
  assign height_eff = (ROW_W+1)'(clamp_dim(height_r, MAX_HEIGHT));
  assign last_col   = ({1'b0, col_r} + (COL_W+1)'(1)) >= width_eff;
  assign last_row   = ({1'b0, row_r} + (ROW_W+1)'(1)) >= height_eff;

  // handshake: the sum stage moves on when the output register has room
  assign s1_move  = s1_valid_r && take;
  assign in_stall = s1_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  // frame position
  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // sum stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // per-pixel control carried alongside the line store read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= col_r;
      s1_above_r <= (row_r != '0);
      s1_fwd_r   <= s1_valid_r && (s1_col_r == col_r);
      s1_end_r   <= last_col && last_row;
    end
  end

  always_comb begin
    ctl.load      = accept;
    ctl.clr_row   = last_col;
    ctl.rd_col    = col_r;
    ctl.move      = s1_move;
    ctl.wr_col    = s1_col_r;
    ctl.use_above = s1_above_r;
    ctl.fwd       = s1_fwd_r;
  end

  // one lane per colour channel
  sat_lane u_lane_red (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_data.red_sample),
    .sum    (red_sum)
  );

  sat_lane u_lane_green (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_data.green_sample),
    .sum    (green_sum)
  );

  sat_lane u_lane_blue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_data.blue_sample),
    .sum    (blue_sum)
  );

  sat_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .move      (s1_move),
    .red_sum   (red_sum),
    .green_sum (green_sum),
    .blue_sum  (blue_sum),
    .frame_end (s1_end_r),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // input held back only while both the sum stage and output register are full
  `SAT_ASSERT(a_stall_full, in_stall |-> (s1_valid_r && out_valid && out_stall), "early stall")
  // a pixel leaving the sum stage lands in the output register
  `SAT_ASSERT(a_move_out, s1_move |=> out_valid, "sum stage moved but no result held")
  // the last pixel of a frame returns the position to the top-left corner
  `SAT_ASSERT(a_frame_wrap, accept && last_col && last_row |=> {col_r, row_r} == '0, "no wrap")

endmodule
`default_nettype wire
